@@ hdl/fbpa_pkg.sv @@
// Shared types and constants for the fixed block pool allocator.
// No dependencies; the allocator and the checker import this package.
package fbpa_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = 10;
  localparam int LINK_W     = 11;
  localparam int CNT_W      = 11;
  localparam int BYTES_W    = 17;
  localparam int ADDR_WIDTH = 32;
  localparam int PROD_W     = IDX_W + BYTES_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // A link or head equal to the pool depth marks the end of the free list.
  localparam logic [LINK_W-1:0] END_LINK = LINK_W'(POOL_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(POOL_DEPTH);

  localparam logic [CNT_W-1:0]      RST_CHUNK_COUNT  = 11'd1024;
  localparam logic [BYTES_W-1:0]    RST_CHUNK_BYTES  = 17'd8;
  localparam logic [ADDR_WIDTH-1:0] RST_BASE_ADDRESS = 32'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_REBUILD
  } state_t;

  typedef struct packed {
    op_t              opcode;
    logic [IDX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [IDX_W-1:0]      granted_index;
    logic [ADDR_WIDTH-1:0] granted_address;
    logic [CNT_W-1:0]      used_chunks;
    logic [CNT_W-1:0]      peak_chunks;
  } rsp_t;

endpackage

@@ hdl/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator: a LIFO free list of equal-sized chunks whose
// next links live in one synchronous RAM. Depends on fbpa_pkg and fbpa_ram.
//
// Each request produces one response. Free, an allocate on an empty pool and
// the no-op code report straight from S_IDLE. A successful allocate also
// passes through S_ALLOC, because the popped chunk's next link must come back
// from the link RAM before the head can move. Rebuild answers at once but
// then holds off requests in S_REBUILD while it rewrites the link chain one
// entry per cycle, for chunk_count entries (capped at the pool depth); the
// same pass runs after reset with the reset configuration. The response sits
// in an output register; a new request is taken only when that register will
// be free.
module fixed_block_pool_allocator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  fbpa_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output fbpa_pkg::rsp_t                     rsp,
  input  logic                               cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fbpa_pkg::*;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]      chunk_count;
  logic [BYTES_W-1:0]    chunk_bytes;
  logic [ADDR_WIDTH-1:0] base_address;

  logic [LINK_W-1:0] head;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  peak;
  logic [IDX_W-1:0]  sweep_ptr;
  logic [CNT_W-1:0]  sweep_n;
  logic [IDX_W-1:0]  grant_idx;
  logic [PROD_W-1:0] grant_prod;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  logic             accept;
  logic             head_empty;
  logic [CNT_W-1:0] eff_count;
  logic [CNT_W-1:0] used_inc;
  logic [CNT_W-1:0] used_dec;
  logic [CNT_W-1:0] sweep_inc;
  logic             sweep_last;
  logic             free_in_range;
  logic             free_ok;
  logic             rsp_load;
  rsp_t             rsp_idle;

  assign accept        = req_valid && !req_stall;
  assign head_empty    = head >= END_LINK;
  assign eff_count     = (chunk_count > DEPTH_CNT) ? DEPTH_CNT : chunk_count;
  assign used_inc      = (used < DEPTH_CNT) ? used + CNT_W'(1) : used;
  assign used_dec      = used - CNT_W'(1);
  assign sweep_inc     = {1'b0, sweep_ptr} + CNT_W'(1);
  assign sweep_last    = sweep_inc >= sweep_n;
  assign free_in_range = {1'b0, req.free_index} < eff_count;
  assign free_ok       = free_in_range && (used != '0);

  // A successful allocate reports in the following cycle, from S_ALLOC.
  assign rsp_load = ((state == S_IDLE) && accept && !(req.opcode == OP_ALLOC && !head_empty))
                    || (state == S_ALLOC);

  fbpa_ram #(
    .WIDTH(LINK_W),
    .DEPTH(POOL_DEPTH)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && req.opcode == OP_ALLOC && !head_empty) begin
          state_next = S_ALLOC;
        end else if (accept && req.opcode == OP_REBUILD) begin
          state_next = S_REBUILD;
        end
      end
      S_ALLOC: state_next = S_IDLE;
      S_REBUILD: begin
        if (sweep_n == '0 || sweep_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and link RAM write port.
  always_comb begin
    req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
    ram_we    = 1'b0;
    ram_waddr = sweep_ptr;
    ram_wdata = sweep_last ? END_LINK : sweep_inc;
    case (state)
      S_REBUILD: begin
        ram_we = sweep_n != '0;
      end
      S_IDLE: begin
        if (req_valid && !(rsp_valid && rsp_stall) && req.opcode == OP_FREE && free_ok) begin
          ram_we    = 1'b1;
          ram_waddr = req.free_index;
          ram_wdata = head;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Response for a transaction that reports in the cycle it is taken.
  always_comb begin
    rsp_idle                 = '0;
    rsp_idle.status          = ST_OK;
    rsp_idle.granted_index   = '0;
    rsp_idle.granted_address = '0;
    rsp_idle.used_chunks     = used;
    rsp_idle.peak_chunks     = peak;
    case (req.opcode)
      OP_ALLOC: begin
        if (head_empty) begin
          rsp_idle.status = ST_EMPTY;
        end
      end
      OP_FREE: begin
        if (!free_in_range) begin
          rsp_idle.status = ST_RANGE;
        end else if (used == '0) begin
          rsp_idle.status = ST_NONE;
        end else begin
          rsp_idle.used_chunks = used_dec;
        end
      end
      OP_REBUILD: begin
        rsp_idle.used_chunks = '0;
        rsp_idle.peak_chunks = '0;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_REBUILD;
      chunk_count  <= RST_CHUNK_COUNT;
      chunk_bytes  <= RST_CHUNK_BYTES;
      base_address <= RST_BASE_ADDRESS;
      head         <= '0;
      used         <= '0;
      peak         <= '0;
      sweep_ptr    <= '0;
      sweep_n      <= RST_CHUNK_COUNT;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHUNK_COUNT:  chunk_count  <= cfg_data[CNT_W-1:0];
          CFG_CHUNK_BYTES:  chunk_bytes  <= cfg_data[BYTES_W-1:0];
          CFG_BASE_ADDRESS: base_address <= cfg_data[ADDR_WIDTH-1:0];
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              OP_ALLOC: begin
                if (!head_empty) begin
                  used <= used_inc;
                  if (used_inc > peak) begin
                    peak <= used_inc;
                  end
                end
              end
              OP_FREE: begin
                if (free_ok) begin
                  head <= {1'b0, req.free_index};
                  used <= used_dec;
                end
              end
              OP_REBUILD: begin
                used      <= '0;
                peak      <= '0;
                sweep_ptr <= '0;
                sweep_n   <= eff_count;
                head      <= (eff_count != '0) ? '0 : END_LINK;
              end
              default: ;
            endcase
          end
        end
        S_ALLOC: begin
          head <= ram_rdata;
        end
        S_REBUILD: begin
          sweep_ptr <= sweep_inc[IDX_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Response payload and the address product.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          grant_idx  <= head[IDX_W-1:0];
          grant_prod <= PROD_W'(head[IDX_W-1:0]) * PROD_W'(chunk_bytes);
          rsp        <= rsp_idle;
        end
      end
      S_ALLOC: begin
        rsp.status          <= ST_OK;
        rsp.granted_index   <= grant_idx;
        rsp.granted_address <= base_address + ADDR_WIDTH'(grant_prod);
        rsp.used_chunks     <= used;
        rsp.peak_chunks     <= peak;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/fbpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fbpa_checker.sv @@
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg.
module fbpa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input fbpa_pkg::req_t                  req,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input fbpa_pkg::rsp_t                  rsp,
  input logic                            cfg_we,
  input logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbpa_pkg::*;

  // A response that is held back must stay put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Only a successful allocate hands out a chunk.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.granted_index == '0 && rsp.granted_address == '0)
    else $error("failed transaction reports a granted chunk");

  // The peak never trails the in-use count.
  a_peak: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.used_chunks <= rsp.peak_chunks)
    else $error("peak below in-use count");

  // The in-use count saturates at the pool depth.
  a_used_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.used_chunks <= DEPTH_CNT)
    else $error("in-use count above pool depth");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
